// ===== src/mscu_pkg.sv =====
// ---------------------------------------------------------------------------
// mscu_pkg: shared types, constants and helpers
// Item and result layouts, fixed-point constants and saturation functions
// for the masked spatial covariance update.
// ---------------------------------------------------------------------------
package mscu_pkg;

  localparam int CHAN_COUNT_DEF = 8;
  localparam int BIN_COUNT_DEF  = 512;
  localparam int MQ_DEPTH       = 4;
  localparam int OQ_DEPTH       = 8;

  localparam logic [16:0]        ONE_Q16   = 17'h10000;
  localparam logic [32:0]        A30_ONE   = 33'h040000000;
  localparam logic [50:0]        RND_Q30   = 51'h20000;
  localparam logic signed [63:0] RND_BLEND = 64'sh20000000;
  localparam logic signed [34:0] SAT_MAX   = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] SAT_MIN   = 35'sh7_8000_0000;

  typedef struct packed {
    logic               bad;
    logic               is_auto;
    logic [4:0]         pair;
    logic [8:0]         bin;
    logic [30:0]        a30;
    logic signed [31:0] spec_re;
    logic signed [31:0] spec_im;
  } mscu_item_t;

  typedef struct packed {
    logic       bad;
    logic       is_auto;
    logic [4:0] pair;
    logic [8:0] bin;
  } mscu_meta_t;

  typedef struct packed {
    logic [4:0]         pair_number;
    logic               is_auto;
    logic [8:0]         bin;
    logic signed [31:0] cov_re;
    logic signed [31:0] cov_im;
    logic               bad_index;
  } mscu_result_t;

  function automatic int depth_w(input int d);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

  function automatic int pair_total(input int nc);
    return nc * (nc - 1) / 2;
  endfunction

  function automatic int addr_w(input int nc, input int nb);
    int cd;
    int ad;
    cd = pair_total(nc) * nb;
    ad = nc * nb;
    return depth_w((cd > ad) ? cd : ad);
  endfunction

  function automatic logic [16:0] sat_q16(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/mscu_ram.sv =====
// ---------------------------------------------------------------------------
// mscu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (read-first).
// ---------------------------------------------------------------------------
module mscu_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/mscu_queue.sv =====
// ---------------------------------------------------------------------------
// mscu_queue: small first-in first-out queue
// Holds items between two sides; head is shown while not empty.
// ---------------------------------------------------------------------------
module mscu_queue #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign do_push = push_i && (count_q != CW'(DEPTH));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// ===== src/mscu_front.sv =====
// ---------------------------------------------------------------------------
// mscu_front: item intake and classification
// Checks indexes, forms pair number and address, the Q1.30 rate and the
// saturated spectrum term, and hands each item to the middle queue.
// ---------------------------------------------------------------------------
module mscu_front #(
  parameter int  CHAN_COUNT = mscu_pkg::CHAN_COUNT_DEF,
  parameter int  BIN_COUNT  = mscu_pkg::BIN_COUNT_DEF,
  localparam int AW         = mscu_pkg::addr_w(CHAN_COUNT, BIN_COUNT),
  localparam int QCW        = $clog2(mscu_pkg::MQ_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic [8:0]          bin_index_i,
  input  logic [2:0]          chan_a_i,
  input  logic [2:0]          chan_b_i,
  input  logic signed [15:0]  sample_a_re_i,
  input  logic signed [15:0]  sample_a_im_i,
  input  logic signed [15:0]  sample_b_re_i,
  input  logic signed [15:0]  sample_b_im_i,
  input  logic [16:0]         gain_a_i,
  input  logic [16:0]         gain_b_i,
  input  logic                clr_busy_i,
  input  logic [QCW-1:0]      mq_count_i,
  output logic                item_push_o,
  output mscu_pkg::mscu_item_t item_o,
  output logic [AW-1:0]       addr_o
);

  import mscu_pkg::*;

  localparam int PW = depth_w(pair_total(CHAN_COUNT));

  logic [16:0]  rate_q;
  logic         accept;
  logic         bad_in, auto_in;
  logic [9:0]   tri_in, pair_full;
  logic [PW-1:0] pair_in;
  logic signed [15:0] br_in, bi_in;

  logic                f1_valid_q;
  logic                f1_bad_q, f1_auto_q;
  logic [PW-1:0]       f1_pair_q;
  logic [2:0]          f1_chan_q;
  logic [8:0]          f1_bin_q;
  logic [33:0]         f1_rg_q;
  logic [16:0]         f1_gb_q;
  logic signed [31:0]  f1_p0_q, f1_p1_q, f1_p2_q, f1_p3_q;

  logic [50:0]         rate_full;
  logic [32:0]         rate_rnd;
  logic [30:0]         a30;
  logic [AW-1:0]       cross_addr, auto_addr;
  mscu_item_t          item_d;

  logic                f2_valid_q;
  mscu_item_t          f2_item_q;
  logic [AW-1:0]       f2_addr_q;

  assign full   = clr_busy_i ||
                  ((int'(mq_count_i) + int'(f1_valid_q) + int'(f2_valid_q)) >= MQ_DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    bad_in    = (chan_a_i > chan_b_i) || (int'(chan_a_i) >= CHAN_COUNT) ||
                (int'(chan_b_i) >= CHAN_COUNT) || (int'(bin_index_i) >= BIN_COUNT);
    auto_in   = (chan_a_i == chan_b_i);
    tri_in    = (10'(chan_a_i) * (10'(2 * CHAN_COUNT - 1) - 10'(chan_a_i))) >> 1;
    pair_full = tri_in + 10'(chan_b_i) - 10'(chan_a_i) - 10'd1;
    pair_in   = (bad_in || auto_in) ? '0 : PW'(pair_full);
    br_in     = auto_in ? sample_a_re_i : sample_b_re_i;
    bi_in     = auto_in ? sample_a_im_i : sample_b_im_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_bad_q  <= bad_in;
      f1_auto_q <= auto_in && !bad_in;
      f1_pair_q <= pair_in;
      f1_chan_q <= chan_a_i;
      f1_bin_q  <= bin_index_i;
      f1_rg_q   <= 34'(sat_q16(rate_q)) * 34'(sat_q16(gain_a_i));
      f1_gb_q   <= sat_q16(gain_b_i);
      f1_p0_q   <= 32'(sample_a_re_i) * 32'(br_in);
      f1_p1_q   <= 32'(sample_a_im_i) * 32'(bi_in);
      f1_p2_q   <= 32'(sample_a_im_i) * 32'(br_in);
      f1_p3_q   <= 32'(sample_a_re_i) * 32'(bi_in);
    end
  end

  always_comb begin
    rate_full  = 51'(f1_rg_q) * 51'(f1_gb_q);
    rate_rnd   = 33'((rate_full + RND_Q30) >> 18);
    a30        = (rate_rnd > A30_ONE) ? A30_ONE[30:0] : rate_rnd[30:0];
    cross_addr = AW'(f1_pair_q) * AW'(BIN_COUNT) + AW'(f1_bin_q);
    auto_addr  = AW'(f1_chan_q) * AW'(BIN_COUNT) + AW'(f1_bin_q);
    item_d.bad     = f1_bad_q;
    item_d.is_auto = f1_auto_q;
    item_d.pair    = 5'(f1_pair_q);
    item_d.bin     = f1_bin_q;
    item_d.a30     = a30;
    item_d.spec_re = sat32(35'(f1_p0_q) + 35'(f1_p1_q));
    item_d.spec_im = sat32(35'(f1_p2_q) - 35'(f1_p3_q));
  end

  always_ff @(posedge clk_i) begin
    if (f1_valid_q) begin
      f2_item_q <= item_d;
      f2_addr_q <= f1_auto_q ? auto_addr : cross_addr;
    end
  end

  assign item_push_o = f2_valid_q;
  assign item_o      = f2_item_q;
  assign addr_o      = f2_addr_q;

endmodule

// ===== src/mscu_back.sv =====
// ---------------------------------------------------------------------------
// mscu_back: term store update
// Reads the stored term, blends it toward the spectrum with forwarding of
// recent writes, saturates, writes back and pushes the result.
// ---------------------------------------------------------------------------
module mscu_back #(
  parameter int  CHAN_COUNT = mscu_pkg::CHAN_COUNT_DEF,
  parameter int  BIN_COUNT  = mscu_pkg::BIN_COUNT_DEF,
  localparam int AW         = mscu_pkg::addr_w(CHAN_COUNT, BIN_COUNT),
  localparam int QCW        = $clog2(mscu_pkg::OQ_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  mscu_pkg::mscu_item_t  head_i,
  input  logic [AW-1:0]         head_addr_i,
  output logic                  head_pop_o,
  input  logic [QCW-1:0]        oq_count_i,
  output logic                  res_push_o,
  output mscu_pkg::mscu_result_t res_o,
  output logic                  clr_busy_o
);

  import mscu_pkg::*;

  localparam int CDEPTH = pair_total(CHAN_COUNT) * BIN_COUNT;
  localparam int ADEPTH = CHAN_COUNT * BIN_COUNT;
  localparam int MAXD   = (CDEPTH > ADEPTH) ? CDEPTH : ADEPTH;
  localparam int CAW    = depth_w(CDEPTH);
  localparam int AAW    = depth_w(ADEPTH);
  localparam int CLW    = depth_w(MAXD);

  logic             clr_busy_q;
  logic [CLW-1:0]   clr_cnt_q;

  logic             issue, hazard;

  logic             s1_valid_q;
  mscu_item_t       s1_q;
  logic [AW-1:0]    s1_addr_q;

  logic             s2_valid_q;
  mscu_meta_t       s2_q;
  logic [AW-1:0]    s2_addr_q;
  logic signed [31:0] s2_old_re_q, s2_old_im_q;
  logic signed [63:0] s2_prod_re_q, s2_prod_im_q;

  logic             s3_valid_q;
  mscu_meta_t       s3_q;
  logic [AW-1:0]    s3_addr_q;
  logic signed [31:0] s3_re_q, s3_im_q;

  logic             s4_wr_q, s4_auto_q;
  logic [AW-1:0]    s4_addr_q;
  logic signed [31:0] s4_re_q, s4_im_q;

  logic [63:0]      cross_rdata;
  logic [31:0]      auto_rdata;
  logic             cross_we, auto_we;
  logic [CAW-1:0]   cross_waddr;
  logic [AAW-1:0]   auto_waddr;
  logic [63:0]      cross_wdata;
  logic [31:0]      auto_wdata;

  logic             hit3, hit4, s3_wr;
  logic signed [31:0] old_re, old_im;
  logic signed [32:0] diff_re, diff_im;
  logic signed [63:0] prod_re, prod_im, rnd_re, rnd_im;
  logic signed [33:0] chg_re, chg_im;
  logic signed [31:0] new_re, new_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == CLW'(MAXD - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign clr_busy_o = clr_busy_q;

  assign hazard = s1_valid_q && !s1_q.bad && !head_i.bad &&
                  (s1_q.is_auto == head_i.is_auto) && (s1_addr_q == head_addr_i);
  assign issue  = head_valid_i && !clr_busy_q && !hazard &&
                  ((int'(oq_count_i) + int'(s1_valid_q) + int'(s2_valid_q) +
                    int'(s3_valid_q)) < OQ_DEPTH);
  assign head_pop_o = issue;

  assign s3_wr = s3_valid_q && !s3_q.bad;

  always_comb begin
    cross_we    = clr_busy_q ? (int'(clr_cnt_q) < CDEPTH) : (s3_wr && !s3_q.is_auto);
    auto_we     = clr_busy_q ? (int'(clr_cnt_q) < ADEPTH) : (s3_wr && s3_q.is_auto);
    cross_waddr = clr_busy_q ? CAW'(clr_cnt_q) : s3_addr_q[CAW-1:0];
    auto_waddr  = clr_busy_q ? AAW'(clr_cnt_q) : s3_addr_q[AAW-1:0];
    cross_wdata = clr_busy_q ? '0 : {s3_re_q, s3_im_q};
    auto_wdata  = clr_busy_q ? '0 : s3_re_q;
  end

  mscu_ram #(
    .WIDTH (64),
    .DEPTH (CDEPTH)
  ) u_cross_ram (
    .clk_i   (clk_i),
    .we_i    (cross_we),
    .waddr_i (cross_waddr),
    .wdata_i (cross_wdata),
    .raddr_i (head_addr_i[CAW-1:0]),
    .rdata_o (cross_rdata)
  );

  mscu_ram #(
    .WIDTH (32),
    .DEPTH (ADEPTH)
  ) u_auto_ram (
    .clk_i   (clk_i),
    .we_i    (auto_we),
    .waddr_i (auto_waddr),
    .wdata_i (auto_wdata),
    .raddr_i (head_addr_i[AAW-1:0]),
    .rdata_o (auto_rdata)
  );

  always_comb begin
    hit3 = s3_wr && (s3_q.is_auto == s1_q.is_auto) && (s3_addr_q == s1_addr_q);
    hit4 = s4_wr_q && (s4_auto_q == s1_q.is_auto) && (s4_addr_q == s1_addr_q);
    if (hit3) begin
      old_re = s3_re_q;
      old_im = s3_im_q;
    end else if (hit4) begin
      old_re = s4_re_q;
      old_im = s4_im_q;
    end else if (s1_q.is_auto) begin
      old_re = auto_rdata;
      old_im = '0;
    end else begin
      old_re = cross_rdata[63:32];
      old_im = cross_rdata[31:0];
    end
    diff_re = 33'(s1_q.spec_re) - 33'(old_re);
    diff_im = 33'(s1_q.spec_im) - 33'(old_im);
    prod_re = 64'(diff_re) * $signed(64'(s1_q.a30));
    prod_im = 64'(diff_im) * $signed(64'(s1_q.a30));
  end

  always_comb begin
    rnd_re = s2_prod_re_q + RND_BLEND;
    rnd_im = s2_prod_im_q + RND_BLEND;
    chg_re = rnd_re[63:30];
    chg_im = rnd_im[63:30];
    new_re = sat32(35'(s2_old_re_q) + 35'(chg_re));
    new_im = sat32(35'(s2_old_im_q) + 35'(chg_im));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_wr_q    <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_wr_q    <= s3_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q      <= head_i;
      s1_addr_q <= head_addr_i;
    end
    if (s1_valid_q) begin
      s2_q.bad     <= s1_q.bad;
      s2_q.is_auto <= s1_q.is_auto;
      s2_q.pair    <= s1_q.pair;
      s2_q.bin     <= s1_q.bin;
      s2_addr_q    <= s1_addr_q;
      s2_old_re_q  <= old_re;
      s2_old_im_q  <= old_im;
      s2_prod_re_q <= prod_re;
      s2_prod_im_q <= prod_im;
    end
    if (s2_valid_q) begin
      s3_q      <= s2_q;
      s3_addr_q <= s2_addr_q;
      s3_re_q   <= s2_q.bad ? '0 : new_re;
      s3_im_q   <= (s2_q.bad || s2_q.is_auto) ? '0 : new_im;
    end
    s4_auto_q <= s3_q.is_auto;
    s4_addr_q <= s3_addr_q;
    s4_re_q   <= s3_re_q;
    s4_im_q   <= s3_im_q;
  end

  assign res_push_o        = s3_valid_q;
  assign res_o.pair_number = s3_q.pair;
  assign res_o.is_auto     = s3_q.is_auto;
  assign res_o.bin         = s3_q.bin;
  assign res_o.cov_re      = s3_re_q;
  assign res_o.cov_im      = s3_im_q;
  assign res_o.bad_index   = s3_q.bad;

endmodule

// ===== src/masked_spatial_covariance_update.sv =====
// ---------------------------------------------------------------------------
// masked_spatial_covariance_update: masked recursive covariance update
// Blends stored cross and auto spectrum terms per channel pair and bin.
// ---------------------------------------------------------------------------
// Takes one item per clock while full is low and returns one result per
// item, in order. Items flow through a two-stage front (rate and spectrum
// products), a four-entry middle queue and a four-stage back end built
// around the term RAM read-modify-write loop, then the output queue. Two
// back-to-back items that hit the same stored term hold the second at the
// middle queue head while the first is in back stage s1. After reset the
// block sweeps both RAMs to zero, one entry per cycle, over
// max(pair count, CHAN_COUNT) * BIN_COUNT entries (14336 at the defaults);
// full stays high meanwhile, and the rate register can still be written.
module masked_spatial_covariance_update #(
  parameter int  CHAN_COUNT = mscu_pkg::CHAN_COUNT_DEF,
  parameter int  BIN_COUNT  = mscu_pkg::BIN_COUNT_DEF,
  localparam int AW         = mscu_pkg::addr_w(CHAN_COUNT, BIN_COUNT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [8:0]         bin_index_i,
  input  logic [2:0]         chan_a_i,
  input  logic [2:0]         chan_b_i,
  input  logic signed [15:0] sample_a_re_i,
  input  logic signed [15:0] sample_a_im_i,
  input  logic signed [15:0] sample_b_re_i,
  input  logic signed [15:0] sample_b_im_i,
  input  logic [16:0]        gain_a_i,
  input  logic [16:0]        gain_b_i,
  output logic               empty,
  input  logic               pop,
  output logic [4:0]         pair_number_o,
  output logic               is_auto_o,
  output logic [8:0]         bin_out_o,
  output logic signed [31:0] cov_re_o,
  output logic signed [31:0] cov_im_o,
  output logic               bad_index_o
);

  import mscu_pkg::*;

  localparam int MQW  = $bits(mscu_item_t) + AW;
  localparam int MQCW = $clog2(MQ_DEPTH + 1);
  localparam int OQCW = $clog2(OQ_DEPTH + 1);

  logic              clr_busy;
  logic              f_push;
  mscu_item_t        f_item;
  logic [AW-1:0]     f_addr;
  logic [MQCW-1:0]   mq_count;
  logic              mq_empty, mq_pop;
  logic [MQW-1:0]    mq_data;
  mscu_item_t        head_item;
  logic [AW-1:0]     head_addr;
  logic              res_push;
  mscu_result_t      res_in, res_out;
  logic [OQCW-1:0]   oq_count;

  mscu_front #(
    .CHAN_COUNT (CHAN_COUNT),
    .BIN_COUNT  (BIN_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .bin_index_i   (bin_index_i),
    .chan_a_i      (chan_a_i),
    .chan_b_i      (chan_b_i),
    .sample_a_re_i (sample_a_re_i),
    .sample_a_im_i (sample_a_im_i),
    .sample_b_re_i (sample_b_re_i),
    .sample_b_im_i (sample_b_im_i),
    .gain_a_i      (gain_a_i),
    .gain_b_i      (gain_b_i),
    .clr_busy_i    (clr_busy),
    .mq_count_i    (mq_count),
    .item_push_o   (f_push),
    .item_o        (f_item),
    .addr_o        (f_addr)
  );

  mscu_queue #(
    .WIDTH (MQW),
    .DEPTH (MQ_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_item, f_addr}),
    .pop_i   (mq_pop),
    .data_o  (mq_data),
    .empty_o (mq_empty),
    .count_o (mq_count)
  );

  assign {head_item, head_addr} = mq_data;

  mscu_back #(
    .CHAN_COUNT (CHAN_COUNT),
    .BIN_COUNT  (BIN_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!mq_empty),
    .head_i       (head_item),
    .head_addr_i  (head_addr),
    .head_pop_o   (mq_pop),
    .oq_count_i   (oq_count),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .clr_busy_o   (clr_busy)
  );

  mscu_queue #(
    .WIDTH ($bits(mscu_result_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty),
    .count_o (oq_count)
  );

  assign pair_number_o = res_out.pair_number;
  assign is_auto_o     = res_out.is_auto;
  assign bin_out_o     = res_out.bin;
  assign cov_re_o      = res_out.cov_re;
  assign cov_im_o      = res_out.cov_im;
  assign bad_index_o   = res_out.bad_index;

endmodule
